// ===== rtl/core/tad_pkg.sv =====
package tad_pkg;

    localparam int unsigned SAMPLE_BITS_DEF  = 10;
    localparam int unsigned CORDIC_STEPS_DEF = 16;

    localparam int unsigned ITER_W     = 5;
    localparam int unsigned ANGLE_W    = 16;
    localparam int unsigned MAG_W      = 15;
    localparam int unsigned RAD_DEG_W  = 22;
    localparam int unsigned PROD_W     = MAG_W + RAD_DEG_W;
    localparam int unsigned DEG_SHIFT  = 30;
    localparam int unsigned LIMIT_W    = 7;
    localparam int unsigned DEG_W      = 8;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned OUT_W      = 24;

    localparam logic [RAD_DEG_W-1:0] RAD_TO_DEG_Q16 = 22'd3754936;
    localparam logic [LIMIT_W-1:0]   DEG_MAX        = 7'd90;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = 7'd30;

    localparam int unsigned X_OFF_RESET = 502;
    localparam int unsigned Y_OFF_RESET = 497;
    localparam int unsigned Z_OFF_RESET = 512;

    localparam logic [CFG_ADDR_W-1:0] REG_X_OFF = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_OFF = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_Z_OFF = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT = 2'd3;

    typedef struct packed {
        logic              load;
        logic              square;
        logic              sqrt_load;
        logic              sqrt_step;
        logic              cordic_load;
        logic              cordic_step;
        logic [ITER_W-1:0] iter;
        logic              deg_load;
        logic              out_load;
    } t_dp_cmd;

    function automatic logic [ANGLE_W-1:0] atan_q14(input logic [ITER_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 16'd12868;
            5'd1:    v = 16'd7596;
            5'd2:    v = 16'd4014;
            5'd3:    v = 16'd2037;
            5'd4:    v = 16'd1023;
            5'd5:    v = 16'd512;
            5'd6:    v = 16'd256;
            5'd7:    v = 16'd128;
            5'd8:    v = 16'd64;
            5'd9:    v = 16'd32;
            5'd10:   v = 16'd16;
            5'd11:   v = 16'd8;
            5'd12:   v = 16'd4;
            5'd13:   v = 16'd2;
            5'd14:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/tad_ctrl.sv =====
module tad_ctrl
    import tad_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    output t_dp_cmd o_cmd
);

    localparam int unsigned SQRT_STEPS = SAMPLE_BITS + 9;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SQUARE  = 3'd1;
    localparam logic [2:0] ST_SQRT_LD = 3'd2;
    localparam logic [2:0] ST_SQRT    = 3'd3;
    localparam logic [2:0] ST_CORD_LD = 3'd4;
    localparam logic [2:0] ST_CORDIC  = 3'd5;
    localparam logic [2:0] ST_DEG     = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic              r_m_valid, n_m_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.iter = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_SQRT_LD;
            end
            ST_SQRT_LD: begin
                o_cmd.sqrt_load = 1'b1;
                n_cnt           = '0;
                n_state         = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == ITER_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_CORD_LD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_CORD_LD: begin
                o_cmd.cordic_load = 1'b1;
                n_cnt             = '0;
                n_state           = ST_CORDIC;
            end
            ST_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (r_cnt == ITER_W'(CORDIC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DEG;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DEG: begin
                o_cmd.deg_load = 1'b1;
                n_state        = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

// ===== rtl/core/tad_lane.sv =====
module tad_lane
    import tad_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  t_dp_cmd                   i_cmd,
    input  logic [2*SAMPLE_BITS:0]    i_sq_sum,
    input  logic signed [SAMPLE_BITS:0] i_num,
    input  logic [LIMIT_W-1:0]        i_limit,
    output logic signed [DEG_W-1:0]   o_deg,
    output logic                      o_over
);

    localparam int unsigned ROOT_W = SAMPLE_BITS + 9;
    localparam int unsigned RAD_W  = 2 * ROOT_W;
    localparam int unsigned CW     = SAMPLE_BITS + 12;

    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [ROOT_W:0]   r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [ROOT_W+2:0] w_rem_t, w_trial, w_diff;
    logic              w_ge;

    logic signed [CW-1:0]      r_x, r_y, n_x, n_y;
    logic signed [ANGLE_W-1:0] r_z, n_z;
    logic signed [CW-1:0]      w_xs, w_ys;
    logic                      w_y_pos, w_y_neg;
    logic [ANGLE_W-1:0]        w_atan;

    logic [ANGLE_W-1:0]  w_z_abs;
    logic [MAG_W-1:0]    w_mag;
    logic [PROD_W-1:0]   w_prod, r_m;
    logic                r_neg;
    logic [LIMIT_W-1:0]  w_deg_u, w_deg_c;
    logic signed [DEG_W-1:0] w_deg_pos;

    assign w_rem_t = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_rem_t >= w_trial);
    assign w_diff  = w_rem_t - w_trial;
    assign n_rem   = w_ge ? w_diff[ROOT_W:0] : w_rem_t[ROOT_W:0];
    assign n_root  = {r_root[ROOT_W-2:0], w_ge};
    assign n_rad   = {r_rad[RAD_W-3:0], 2'b00};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_rad  <= {1'b0, i_sq_sum, 16'd0};
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign w_xs    = r_x >>> i_cmd.iter;
    assign w_ys    = r_y >>> i_cmd.iter;
    assign w_y_neg = r_y[CW-1];
    assign w_y_pos = !r_y[CW-1] && (r_y != '0);
    assign w_atan  = atan_q14(i_cmd.iter);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (w_y_pos) begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + $signed(w_atan);
        end else if (w_y_neg) begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - $signed(w_atan);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_load) begin
            r_x <= $signed({3'b000, r_root});
            r_y <= $signed({{3{i_num[SAMPLE_BITS]}}, i_num, 8'd0});
            r_z <= '0;
        end else if (i_cmd.cordic_step) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign w_z_abs = r_z[ANGLE_W-1] ? 16'(-r_z) : 16'(r_z);
    assign w_mag   = w_z_abs[MAG_W-1:0];
    assign w_prod  = w_mag * RAD_TO_DEG_Q16;

    always_ff @(posedge i_clk) begin
        if (i_cmd.deg_load) begin
            r_m   <= w_prod;
            r_neg <= r_z[ANGLE_W-1];
        end
    end

    assign w_deg_u   = r_m[PROD_W-1:DEG_SHIFT];
    assign w_deg_c   = (w_deg_u > DEG_MAX) ? DEG_MAX : w_deg_u;
    assign w_deg_pos = $signed({1'b0, w_deg_c});
    assign o_deg     = r_neg ? -w_deg_pos : w_deg_pos;
    assign o_over    = (r_m > {i_limit, {DEG_SHIFT{1'b0}}});

endmodule

// ===== rtl/core/tad_dp.sv =====
module tad_dp
    import tad_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [SAMPLE_BITS-1:0]  i_cfg_wdata,
    input  logic [SAMPLE_BITS-1:0]  i_x,
    input  logic [SAMPLE_BITS-1:0]  i_y,
    input  logic [SAMPLE_BITS-1:0]  i_z,
    output logic signed [DEG_W-1:0] o_pitch,
    output logic signed [DEG_W-1:0] o_roll,
    output logic                    o_level
);

    localparam int unsigned SB   = SAMPLE_BITS;
    localparam int unsigned SQ_W = 2 * SB + 1;

    logic [SB-1:0]      r_x_off, r_y_off, r_z_off;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_prior;

    logic signed [SB:0]     r_dx, r_dy, r_dz, n_dx, n_dy, n_dz;
    logic signed [2*SB+1:0] w_x2, w_y2, w_z2;
    logic [2*SB-1:0]        r_x2, r_y2, r_z2;
    logic [SQ_W-1:0]        w_sum_p, w_sum_r;

    logic signed [DEG_W-1:0] w_pitch, w_roll, r_pitch, r_roll;
    logic                    w_over_p, w_over_r, w_tilt;
    logic                    r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_off <= SB'(X_OFF_RESET);
            r_y_off <= SB'(Y_OFF_RESET);
            r_z_off <= SB'(Z_OFF_RESET);
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_X_OFF: r_x_off <= i_cfg_wdata;
                REG_Y_OFF: r_y_off <= i_cfg_wdata;
                REG_Z_OFF: r_z_off <= i_cfg_wdata;
                REG_LIMIT: r_limit <= i_cfg_wdata[LIMIT_W-1:0];
            endcase
        end
    end

    assign n_dx = $signed({1'b0, i_x}) - $signed({1'b0, r_x_off});
    assign n_dy = $signed({1'b0, i_y}) - $signed({1'b0, r_y_off});
    assign n_dz = $signed({1'b0, i_z}) - $signed({1'b0, r_z_off});

    assign w_x2 = r_dx * r_dx;
    assign w_y2 = r_dy * r_dy;
    assign w_z2 = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_dz <= n_dz;
        end
        if (i_cmd.square) begin
            r_x2 <= w_x2[2*SB-1:0];
            r_y2 <= w_y2[2*SB-1:0];
            r_z2 <= w_z2[2*SB-1:0];
        end
    end

    assign w_sum_p = {1'b0, r_y2} + {1'b0, r_z2};
    assign w_sum_r = {1'b0, r_x2} + {1'b0, r_z2};

    tad_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_pitch (
        .i_clk    (i_clk),
        .i_cmd    (i_cmd),
        .i_sq_sum (w_sum_p),
        .i_num    (r_dx),
        .i_limit  (r_limit),
        .o_deg    (w_pitch),
        .o_over   (w_over_p)
    );

    tad_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_roll (
        .i_clk    (i_clk),
        .i_cmd    (i_cmd),
        .i_sq_sum (w_sum_r),
        .i_num    (r_dy),
        .i_limit  (r_limit),
        .o_deg    (w_roll),
        .o_over   (w_over_r)
    );

    assign w_tilt = w_over_p || w_over_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_prior <= w_tilt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pitch <= w_pitch;
            r_roll  <= w_roll;
            r_level <= !(w_tilt && r_prior);
        end
    end

    assign o_pitch = r_pitch;
    assign o_roll  = r_roll;
    assign o_level = r_level;

endmodule

// ===== rtl/core/accel_tilt_angle_detector.sv =====
// Channel    Direction  Handshake                           Payload
// s_axis     in         i_s_axis_tvalid / o_s_axis_tready   x, y, z sample codes
// m_axis     out        o_m_axis_tvalid / i_m_axis_tready   pitch, roll, level
// cfg        in         i_cfg_we                            register index, write data
//
// Each sample runs through the bit-per-cycle square root (SAMPLE_BITS + 9 steps)
// followed by the CORDIC vectoring pass (CORDIC_STEPS steps) before the next sample
// is accepted; both axes run in parallel lanes. Reset restores the register defaults
// and clears the tilt history.
// A result held in the output register does not block the next sample; only a new
// result waits while the previous one is still unclaimed.
module accel_tilt_angle_detector
    import tad_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // x_sample, y_sample, z_sample
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // pitch_deg, roll_deg, level
    output logic [OUT_W-1:0]       o_m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [SAMPLE_BITS-1:0] i_cfg_wdata
);

    localparam int unsigned SB = SAMPLE_BITS;

    t_dp_cmd                 w_cmd;
    logic signed [DEG_W-1:0] w_pitch, w_roll;
    logic                    w_level;

    tad_ctrl #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (w_cmd)
    );

    tad_dp #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_x         (i_s_axis_tdata[SB-1:0]),
        .i_y         (i_s_axis_tdata[2*SB-1:SB]),
        .i_z         (i_s_axis_tdata[3*SB-1:2*SB]),
        .o_pitch     (w_pitch),
        .o_roll      (w_roll),
        .o_level     (w_level)
    );

    assign o_m_axis_tdata = {{(OUT_W-2*DEG_W-1){1'b0}}, w_level, w_roll, w_pitch};

endmodule

// ===== verif/tilt_checker.sv =====
module tilt_checker
    import tad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // x_sample, y_sample, z_sample
    input  logic [31:0]           i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // pitch_deg, roll_deg, level
    input  logic [OUT_W-1:0]      i_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [9:0]            i_cfg_wdata,
    output int                    o_error_count,
    output int                    o_pending
);

    localparam int SB     = SAMPLE_BITS_DEF;
    localparam int NSTEPS = CORDIC_STEPS_DEF;

    typedef struct packed {
        logic signed [DEG_W-1:0] pitch;
        logic signed [DEG_W-1:0] roll;
        logic                    level;
    } t_tilt;

    longint atan_step_q14 [24] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128,
                                   64, 32, 16, 8, 4, 2, 1, 0,
                                   0, 0, 0, 0, 0, 0, 0, 0};

    logic [SB-1:0]      x_off = SB'(X_OFF_RESET);
    logic [SB-1:0]      y_off = SB'(Y_OFF_RESET);
    logic [SB-1:0]      z_off = SB'(Z_OFF_RESET);
    logic [LIMIT_W-1:0] limit_deg = LIMIT_RESET;
    logic               prior_tilted = 1'b0;
    t_tilt              expected_tilt_q [$];
    int                 errors = 0;

    function automatic longint unsigned isqrt_u64(input longint unsigned n);
        longint unsigned res;
        longint unsigned bits;
        res  = 0;
        bits = 64'd1 << 62;
        while (bits > n)
            bits = bits >> 2;
        while (bits != 0) begin
            if (n >= res + bits) begin
                n   = n - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    // Q2.14 angle of atan2(num, sqrt(a^2 + b^2))
    function automatic longint vector_angle(input longint num, input longint a, input longint b);
        longint xv;
        longint yv;
        longint zv;
        longint xs;
        longint ys;
        int     steps;
        steps = (NSTEPS > 24) ? 24 : NSTEPS;
        xv = longint'(isqrt_u64(longint'(a * a + b * b) << 16));
        yv = num * 256;
        zv = 0;
        for (int k = 0; k < steps; k++) begin
            xs = xv >>> k;
            ys = yv >>> k;
            if (yv > 0) begin
                xv = xv + ys;
                yv = yv - xs;
                zv = zv + atan_step_q14[k];
            end else if (yv < 0) begin
                xv = xv - ys;
                yv = yv + xs;
                zv = zv - atan_step_q14[k];
            end
        end
        return zv;
    endfunction

    function automatic logic signed [DEG_W-1:0] whole_degrees(input longint ang,
                                                              input logic [LIMIT_W-1:0] lim,
                                                              output logic over);
        longint unsigned         mag;
        longint unsigned         prod;
        longint unsigned         deg;
        logic signed [DEG_W-1:0] d;
        mag  = (ang < 0) ? longint'(-ang) : longint'(ang);
        prod = mag * longint'(RAD_TO_DEG_Q16);
        over = prod > (longint'(lim) << DEG_SHIFT);
        deg  = prod >> DEG_SHIFT;
        if (deg > DEG_MAX)
            deg = DEG_MAX;
        d = deg[DEG_W-1:0];
        return (ang < 0) ? -d : d;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [SB-1:0] xs;
        logic [SB-1:0] ys;
        logic [SB-1:0] zs;
        longint        dx;
        longint        dy;
        longint        dz;
        logic          over_p;
        logic          over_r;
        logic          tilted;
        t_tilt         exp_r;
        t_tilt         got_r;
        if (!i_rst_n) begin
            x_off        = SB'(X_OFF_RESET);
            y_off        = SB'(Y_OFF_RESET);
            z_off        = SB'(Z_OFF_RESET);
            limit_deg    = LIMIT_RESET;
            prior_tilted = 1'b0;
            expected_tilt_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_X_OFF: x_off = i_cfg_wdata[SB-1:0];
                    REG_Y_OFF: y_off = i_cfg_wdata[SB-1:0];
                    REG_Z_OFF: z_off = i_cfg_wdata[SB-1:0];
                    REG_LIMIT: limit_deg = i_cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                xs = i_s_tdata[SB-1:0];
                ys = i_s_tdata[2*SB-1:SB];
                zs = i_s_tdata[3*SB-1:2*SB];
                dx = longint'(xs) - longint'(x_off);
                dy = longint'(ys) - longint'(y_off);
                dz = longint'(zs) - longint'(z_off);
                exp_r.pitch  = whole_degrees(vector_angle(dx, dy, dz), limit_deg, over_p);
                exp_r.roll   = whole_degrees(vector_angle(dy, dx, dz), limit_deg, over_r);
                tilted       = over_p | over_r;
                exp_r.level  = !(tilted && prior_tilted);
                prior_tilted = tilted;
                expected_tilt_q.push_back(exp_r);
            end
            if (i_m_tvalid && i_m_tready) begin
                got_r.pitch = i_m_tdata[DEG_W-1:0];
                got_r.roll  = i_m_tdata[2*DEG_W-1:DEG_W];
                got_r.level = i_m_tdata[2*DEG_W];
                if (expected_tilt_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: pitch %0d roll %0d level %0d",
                                 got_r.pitch, got_r.roll, got_r.level);
                end else begin
                    exp_r = expected_tilt_q.pop_front();
                    if (got_r != exp_r) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     exp_r.pitch, exp_r.roll, exp_r.level,
                                     got_r.pitch, got_r.roll, got_r.level);
                    end
                end
            end
        end
        o_error_count <= errors;
        o_pending     <= expected_tilt_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import tad_pkg::*;

    localparam int SB             = SAMPLE_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SEG_ITEMS      = 290;
    localparam int HOLD_CYCLES    = 400;

    logic                  i_clk;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [SB-1:0]         cfg_wdata = '0;

    int send_idle_pct = 34;
    int recv_idle_pct = 60;
    int stall_token   = 0;
    int seen_token    = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int error_count;
    int pending;

    accel_tilt_angle_detector u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    tilt_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // hold off for a long stretch whenever the token moves
    always @(negedge i_clk) begin
        if (stall_token != seen_token) begin
            seen_token <= stall_token;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(input logic [SB-1:0] x, input logic [SB-1:0] y,
                               input logic [SB-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, z, y, x};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (48) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [SB-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [SB-1:0] xo, input logic [SB-1:0] yo,
                                input logic [SB-1:0] zo, input logic [SB-1:0] lim);
        write_reg(REG_X_OFF, xo);
        write_reg(REG_Y_OFF, yo);
        write_reg(REG_Z_OFF, zo);
        write_reg(REG_LIMIT, lim);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [SB-1:0] around(input logic [SB-1:0] centre, input int spread);
        int v;
        v = int'(centre) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        else if (v > 1023)
            v = 1023;
        return v[SB-1:0];
    endfunction

    function automatic logic [SB-1:0] corner_code(input logic [SB-1:0] off);
        case ($urandom_range(2))
            0: return '0;
            1: return '1;
            default: return off;
        endcase
    endfunction

    function automatic logic [SB-1:0] far_code();
        return $urandom_range(1) ? SB'($urandom_range(900, 1023)) : SB'($urandom_range(0, 120));
    endfunction

    task automatic run_random(input logic [SB-1:0] xo, input logic [SB-1:0] yo,
                              input logic [SB-1:0] zo, input bit with_stall);
        int sent;
        int pick;
        int burst;
        int axis;
        bit stalled;
        sent    = 0;
        stalled = 1'b0;
        while (sent < SEG_ITEMS) begin
            if (with_stall && !stalled && sent >= 100) begin
                stall_token <= stall_token + 1;
                stalled = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 20) begin
                // run of strongly tilted samples to walk the level history
                burst = $urandom_range(2, 5);
                axis  = $urandom_range(1);
                repeat (burst) begin
                    if (axis == 0)
                        send_sample(far_code(), around(yo, 40), around(zo, 60));
                    else
                        send_sample(around(xo, 40), far_code(), around(zo, 60));
                    sent++;
                end
            end else if (pick < 70) begin
                send_sample(around(xo, 300), around(yo, 300), around(zo, 300));
                sent++;
            end else if (pick < 90) begin
                send_sample(SB'($urandom), SB'($urandom), SB'($urandom));
                sent++;
            end else begin
                send_sample(corner_code(xo), corner_code(yo), corner_code(zo));
                sent++;
            end
        end
    endtask

    initial begin
        logic [SB-1:0] xo;
        logic [SB-1:0] yo;
        logic [SB-1:0] zo;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_sample(10'd0, 10'd0, 10'd0);
        send_sample(10'd1023, 10'd1023, 10'd1023);
        send_sample(10'd502, 10'd497, 10'd512);
        send_sample(10'd1023, 10'd497, 10'd512);
        send_sample(10'd0, 10'd497, 10'd512);
        send_sample(10'd502, 10'd1023, 10'd512);
        send_sample(10'd502, 10'd0, 10'd512);
        send_sample(10'd502, 10'd497, 10'd1023);
        send_sample(10'd502, 10'd497, 10'd0);
        send_sample(10'd1023, 10'd497, 10'd512);
        send_sample(10'd502, 10'd497, 10'd700);
        send_sample(10'd1023, 10'd497, 10'd512);
        send_sample(10'd0, 10'd1023, 10'd512);
        send_sample(10'h155, 10'h2AA, 10'h155);
        send_sample(10'h2AA, 10'h155, 10'h2AA);
        send_sample(10'd600, 10'd400, 10'd520);
        run_random(10'd502, 10'd497, 10'd512, 1'b1);

        drain();
        program_regs(10'd0, 10'd0, 10'd0, 10'd0);
        run_random(10'd0, 10'd0, 10'd0, 1'b0);

        send_idle_pct = 60;
        recv_idle_pct <= 34;
        drain();
        program_regs(10'd1023, 10'd1023, 10'd1023, 10'd90);
        run_random(10'd1023, 10'd1023, 10'd1023, 1'b0);

        drain();
        program_regs(10'd512, 10'd512, 10'd512, 10'h3FF);
        run_random(10'd512, 10'd512, 10'd512, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        drain();
        xo = SB'($urandom_range(400, 620));
        yo = SB'($urandom_range(400, 620));
        zo = SB'($urandom_range(400, 620));
        program_regs(xo, yo, zo, 10'h3AD);
        run_random(xo, yo, zo, 1'b1);

        drain();
        program_regs(10'd502, 10'd497, 10'd512, 10'd30);
        run_random(10'd502, 10'd497, 10'd512, 1'b0);

        drain();
        repeat (60) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
